// ----- rtl/ufp_pkg.sv -----
// ----------------------------------------------------------------------------
// ufp_pkg
// Types and constants shared by the file URI parser blocks.
// ----------------------------------------------------------------------------
package ufp_pkg;

  // Parse phase, one-hot.
  typedef enum logic [12:0] {
    PH_START  = 13'b0_0000_0000_0001,
    PH_I      = 13'b0_0000_0000_0010,
    PH_L      = 13'b0_0000_0000_0100,
    PH_E      = 13'b0_0000_0000_1000,
    PH_COLON  = 13'b0_0000_0001_0000,
    PH_SLASH1 = 13'b0_0000_0010_0000,
    PH_SLASH2 = 13'b0_0000_0100_0000,
    PH_HOST0  = 13'b0_0000_1000_0000,
    PH_HOST   = 13'b0_0001_0000_0000,
    PH_PATH   = 13'b0_0010_0000_0000,
    PH_PCT    = 13'b0_0100_0000_0000,
    PH_PCT1   = 13'b0_1000_0000_0000,
    PH_SKIP   = 13'b1_0000_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HOST   = 2'd0,
    KIND_PATH   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  localparam int MAX_ITEMS = 6;
  localparam int CNT_W     = 3;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LI    = 8'h69;
  localparam logic [7:0] CH_LL    = 8'h6C;
  localparam logic [7:0] UC_HEX_OFS = 8'h37;
  localparam logic [7:0] LC_HEX_OFS = 8'h57;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       status;
    logic       host_local;
    logic       run_end;
  } item_t;

  // All results caused by one request, in order.
  typedef struct packed {
    item_t [MAX_ITEMS-1:0] items;
    logic  [CNT_W-1:0]     cnt;
  } bundle_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/ufp_in_if.sv -----
// ----------------------------------------------------------------------------
// ufp_in_if
// Input byte channel of the file URI parser.
// ----------------------------------------------------------------------------
interface ufp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       is_final;

  modport source (output valid, output char_in, output is_final, input ready);
  modport sink (input valid, input char_in, input is_final, output ready);
endinterface

// ----- rtl/ufp_out_if.sv -----
// ----------------------------------------------------------------------------
// ufp_out_if
// Result channel of the file URI parser.
// ----------------------------------------------------------------------------
interface ufp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic [7:0] byte_out;
  logic       status_code;
  logic       host_local;
  logic       run_end;

  modport source (output valid, output item_kind, output byte_out, output status_code,
                  output host_local, output run_end, input ready);
  modport sink (input valid, input item_kind, input byte_out, input status_code,
                input host_local, input run_end, output ready);
endinterface

// ----- rtl/ufp_front.sv -----
// ----------------------------------------------------------------------------
// ufp_front
// Accepts input bytes, runs the prefix and percent-decode parser and builds
// the list of results that each byte causes.
// ----------------------------------------------------------------------------
module ufp_front (
  input  logic              clk,
  input  logic              rst_n,
  ufp_in_if.sink            in_ch,
  input  ufp_pkg::q_stat_t  q_stat,
  output logic              push,
  output ufp_pkg::bundle_t  push_data
);
  import ufp_pkg::*;

  typedef struct packed {
    phase_t                phase;
    logic [7:0]            pend;
    logic                  held;
    logic                  nonempty;
    logic                  localhost;
    item_t [MAX_ITEMS-1:0] items;
    logic  [CNT_W-1:0]     cnt;
  } work_t;

  phase_t     phase_r;
  logic [7:0] pend_r;
  logic       held_r;
  logic       nonempty_r;
  logic       local_r;
  work_t      w;
  logic       accept;
  logic       valid_uri;
  item_t      stat_item;

  function automatic logic is_hex(logic [7:0] c);
    return ((c >= CH_0) && (c <= CH_9)) || ((c >= CH_UA) && (c <= CH_UF)) ||
           ((c >= CH_LA) && (c <= CH_LF));
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [7:0] d;
    if ((c >= CH_0) && (c <= CH_9)) begin
      d = c - CH_0;
    end else if ((c >= CH_UA) && (c <= CH_UF)) begin
      d = c - UC_HEX_OFS;
    end else begin
      d = c - LC_HEX_OFS;
    end
    return d[3:0];
  endfunction

  function automatic work_t put_path(work_t wi, logic [7:0] b);
    work_t wo;
    wo = wi;
    wo.items[wo.cnt] = '{kind: KIND_PATH, data: b, status: 1'b0, host_local: 1'b0,
                         run_end: 1'b0};
    wo.cnt = wo.cnt + 3'd1;
    return wo;
  endfunction

  function automatic work_t path_out(work_t wi, logic [7:0] b);
    work_t wo;
    wo = wi;
    if (wo.held) begin
      wo = put_path(wo, CH_SLASH);
      wo.nonempty = 1'b1;
      wo.held = 1'b0;
    end
    if (b == CH_SLASH) begin
      wo.held = 1'b1;
    end else begin
      wo = put_path(wo, b);
      wo.nonempty = 1'b1;
    end
    return wo;
  endfunction

  function automatic work_t path_char(work_t wi, logic [7:0] c);
    work_t wo;
    logic  done;
    wo = wi;
    done = 1'b0;
    if (wo.phase == PH_PCT) begin
      if (is_hex(c)) begin
        wo.pend = c;
        wo.phase = PH_PCT1;
        done = 1'b1;
      end else begin
        wo.phase = PH_PATH;
        wo = path_out(wo, CH_PCT);
      end
    end else if (wo.phase == PH_PCT1) begin
      if (is_hex(c)) begin
        wo.phase = PH_PATH;
        wo = path_out(wo, {hex_val(wo.pend), hex_val(c)});
        wo.pend = '0;
        done = 1'b1;
      end else begin
        wo.phase = PH_PATH;
        wo = path_out(wo, CH_PCT);
        wo = path_out(wo, wo.pend);
        wo.pend = '0;
      end
    end
    if (!done) begin
      if (c == CH_PCT) begin
        wo.phase = PH_PCT;
      end else begin
        wo = path_out(wo, c);
      end
    end
    return wo;
  endfunction

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_stat.full;

  always_comb begin
    w = '0;
    w.phase = phase_r;
    w.pend = pend_r;
    w.held = held_r;
    w.nonempty = nonempty_r;
    w.localhost = local_r;
    valid_uri = 1'b0;
    stat_item = '0;

    unique case (phase_r)
      PH_START: begin
        if (in_ch.char_in == CH_SLASH) begin
          w.localhost = 1'b1;
          w.phase = PH_PATH;
          w = path_char(w, in_ch.char_in);
        end else if (in_ch.char_in == CH_LF) begin
          w.phase = PH_I;
        end else begin
          w.phase = PH_SKIP;
        end
      end
      PH_I:      w.phase = (in_ch.char_in == CH_LI) ? PH_L : PH_SKIP;
      PH_L:      w.phase = (in_ch.char_in == CH_LL) ? PH_E : PH_SKIP;
      PH_E:      w.phase = (in_ch.char_in == CH_LE) ? PH_COLON : PH_SKIP;
      PH_COLON:  w.phase = (in_ch.char_in == CH_COLON) ? PH_SLASH1 : PH_SKIP;
      PH_SLASH1: w.phase = (in_ch.char_in == CH_SLASH) ? PH_SLASH2 : PH_SKIP;
      PH_SLASH2: begin
        if (in_ch.char_in == CH_SLASH) begin
          w.phase = PH_HOST0;
        end else begin
          w.localhost = 1'b1;
          w.phase = PH_PATH;
          w = path_char(w, CH_SLASH);
          w = path_char(w, in_ch.char_in);
        end
      end
      PH_HOST0, PH_HOST: begin
        if (in_ch.char_in == CH_SLASH) begin
          w.localhost = (phase_r == PH_HOST0);
          w.phase = PH_PATH;
          w = path_char(w, in_ch.char_in);
        end else begin
          w.items[w.cnt] = '{kind: KIND_HOST, data: in_ch.char_in, status: 1'b0,
                             host_local: 1'b0, run_end: 1'b0};
          w.cnt = w.cnt + 3'd1;
          w.phase = PH_HOST;
        end
      end
      PH_PATH, PH_PCT, PH_PCT1: w = path_char(w, in_ch.char_in);
      default: w.phase = PH_SKIP;
    endcase

    if (in_ch.is_final) begin
      if (w.phase == PH_SLASH2) begin
        w.localhost = 1'b1;
        w.phase = PH_PATH;
        w = path_char(w, CH_SLASH);
      end
      if ((w.phase == PH_PATH) || (w.phase == PH_PCT) || (w.phase == PH_PCT1)) begin
        if (w.phase == PH_PCT) begin
          w = path_out(w, CH_PCT);
        end else if (w.phase == PH_PCT1) begin
          w = path_out(w, CH_PCT);
          w = path_out(w, w.pend);
        end
        if (w.held && !w.nonempty) begin
          w = put_path(w, CH_SLASH);
        end
        valid_uri = 1'b1;
      end
      stat_item = '{kind: KIND_STATUS, data: 8'h00, status: !valid_uri,
                    host_local: valid_uri && w.localhost, run_end: 1'b1};
      w.items[w.cnt] = stat_item;
      w.cnt = w.cnt + 3'd1;
      w.phase = PH_START;
      w.pend = '0;
      w.held = 1'b0;
      w.nonempty = 1'b0;
      w.localhost = 1'b0;
    end
  end

  assign push = accept && (w.cnt != '0);
  assign push_data = '{items: w.items, cnt: w.cnt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      pend_r <= '0;
      held_r <= 1'b0;
      nonempty_r <= 1'b0;
      local_r <= 1'b0;
    end else if (accept) begin
      phase_r <= w.phase;
      pend_r <= w.pend;
      held_r <= w.held;
      nonempty_r <= w.nonempty;
      local_r <= w.localhost;
    end
  end

endmodule

// ----- rtl/ufp_fifo.sv -----
// ----------------------------------------------------------------------------
// ufp_fifo
// Queue of result bundles between the parser and the result sequencer.
// ----------------------------------------------------------------------------
module ufp_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ufp_pkg::bundle_t  push_data,
  input  logic              pop,
  output ufp_pkg::bundle_t  head,
  output ufp_pkg::q_stat_t  q_stat
);
  import ufp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_Q = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_Q-1:0] FULL_CNT = CNT_Q'(DEPTH);

  bundle_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_Q-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign q_stat.empty = (cnt_r == '0);
  assign do_push = push && !q_stat.full;
  assign do_pop  = pop && !q_stat.empty;
  assign head = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/ufp_back.sv -----
// ----------------------------------------------------------------------------
// ufp_back
// Sends the results of the bundle at the queue head one request at a time.
// ----------------------------------------------------------------------------
module ufp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ufp_pkg::bundle_t  head,
  input  ufp_pkg::q_stat_t  q_stat,
  output logic              pop,
  ufp_out_if.source         out_ch
);
  import ufp_pkg::*;

  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] idx_nxt;
  logic             last_item;
  logic             sent;
  item_t            cur;

  assign cur = head.items[idx_r];
  assign last_item = (idx_r == (head.cnt - 1'b1));
  assign sent = out_ch.valid && out_ch.ready;
  assign pop = sent && last_item;

  assign out_ch.valid       = !q_stat.empty;
  assign out_ch.item_kind   = cur.kind;
  assign out_ch.byte_out    = cur.data;
  assign out_ch.status_code = cur.status;
  assign out_ch.host_local  = cur.host_local;
  assign out_ch.run_end     = cur.run_end;

  always_comb begin
    idx_nxt = idx_r;
    if (sent) begin
      idx_nxt = last_item ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// ----- rtl/file_uri_parser_percent_decode.sv -----
// A streaming file URI parser: one byte of the identifier per request, the
// last one marked, giving host bytes, percent-decoded path bytes and a
// closing status item. A byte is accepted every cycle while the result queue
// has room; the queue holds FIFO_DEPTH byte result lists. Results leave at one
// per cycle while the receiver is ready and the queue is not empty, and a byte
// causes at most five results, so the output port sets the long-run rate. The
// results of a byte are written into the result queue and leave from its head.
// ----------------------------------------------------------------------------
// file_uri_parser_percent_decode
// Top level: parser front, result queue and result sequencer.
// ----------------------------------------------------------------------------
module file_uri_parser_percent_decode #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  ufp_in_if.sink    in_ch,
  ufp_out_if.source out_ch
);
  import ufp_pkg::*;

  logic    push;
  logic    pop;
  bundle_t push_data;
  bundle_t head;
  q_stat_t q_stat;

  ufp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  ufp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  ufp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

`ifndef SYNTHESIS
  a_run_end_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.run_end == (out_ch.item_kind == KIND_STATUS)))
    else $error("run_end does not match a status item");

  a_status_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.item_kind == KIND_STATUS)) |-> (out_ch.byte_out == 8'h00))
    else $error("status item carries a byte");

  a_head_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !q_stat.empty |-> (head.cnt != '0))
    else $error("queued bundle holds no results");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("push into full result queue");
`endif

endmodule

// ----- bench/file_uri_parser_percent_decode_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// file_uri_parser_percent_decode_tb
// Self-checking bench for the streaming file URI parser.
// A short table of hand-picked identifiers comes first. Random identifiers
// follow: bare paths, every scheme form, hosts, escapes and broken prefixes.
// Every accepted byte runs through a parser model in the bench. The results
// that the model predicts, or a fixed result for some table rows, are queued
// and compared field by field with what the block sends. Both sides of the
// block pause at random. One long receiver stall fills the result queue so
// that the block must hold off further requests.
// ----------------------------------------------------------------------------
module file_uri_parser_percent_decode_tb;
  import ufp_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 64;
  localparam int PHASE_BYTES  = 100;

  localparam logic [55:0] SCHEME = {CH_LF, CH_LI, CH_LL, CH_LE, CH_COLON, CH_SLASH, CH_SLASH};
  localparam item_t INVALID_END = {KIND_STATUS, 8'h00, 1'b1, 1'b0, 1'b1};

  typedef struct {
    logic [7:0] ch;
    logic       is_last;
    int         n_fixed;
    item_t      fixed_res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ufp_in_if  in_ch ();
  ufp_out_if out_ch ();

  file_uri_parser_percent_decode dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #4 clk = ~clk;

  phase_t     parse_ph;
  logic [7:0] held_digit;
  logic       slash_pending;
  logic       path_started;
  logic       local_host;

  item_t      step_res[$];
  item_t      pending_items[$];
  logic [7:0] ident_bytes[$];
  stim_row_t  stim_table[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int bytes_sent     = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_left      = 0;
  bit hold_req       = 1'b0;

  function automatic void clear_parser();
    parse_ph      = PH_START;
    held_digit    = 8'h00;
    slash_pending = 1'b0;
    path_started  = 1'b0;
    local_host    = 1'b0;
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_UA && c <= CH_UF) return int'(c - UC_HEX_OFS);
    if (c >= CH_LA && c <= CH_LF) return int'(c - LC_HEX_OFS);
    return -1;
  endfunction

  function automatic void add_res(kind_t k, logic [7:0] b, logic st, logic loc, logic fin);
    item_t it;
    it.kind       = k;
    it.data       = b;
    it.status     = st;
    it.host_local = loc;
    it.run_end    = fin;
    step_res.push_back(it);
  endfunction

  // A slash is held back until another path byte shows it is not trailing.
  function automatic void emit_path(logic [7:0] b);
    if (slash_pending) begin
      add_res(KIND_PATH, CH_SLASH, 1'b0, 1'b0, 1'b0);
      path_started  = 1'b1;
      slash_pending = 1'b0;
    end
    if (b == CH_SLASH) begin
      slash_pending = 1'b1;
    end else begin
      add_res(KIND_PATH, b, 1'b0, 1'b0, 1'b0);
      path_started = 1'b1;
    end
  endfunction

  function automatic void decode_char(logic [7:0] c);
    int hi;
    int lo;
    if (parse_ph == PH_PCT) begin
      if (hex_digit(c) >= 0) begin
        held_digit = c;
        parse_ph   = PH_PCT1;
        return;
      end
      parse_ph = PH_PATH;
      emit_path(CH_PCT);
    end else if (parse_ph == PH_PCT1) begin
      lo = hex_digit(c);
      if (lo >= 0) begin
        hi         = hex_digit(held_digit);
        parse_ph   = PH_PATH;
        held_digit = 8'h00;
        emit_path(8'((hi << 4) | lo));
        return;
      end
      parse_ph = PH_PATH;
      emit_path(CH_PCT);
      emit_path(held_digit);
      held_digit = 8'h00;
    end
    if (c == CH_PCT) begin
      parse_ph = PH_PCT;
    end else begin
      emit_path(c);
    end
  endfunction

  function automatic void predict_byte(logic [7:0] c, logic is_last);
    logic ok;
    ok = 1'b0;
    step_res.delete();
    case (parse_ph)
      PH_START: begin
        if (c == CH_SLASH) begin
          local_host = 1'b1;
          parse_ph   = PH_PATH;
          decode_char(c);
        end else if (c == CH_LF) begin
          parse_ph = PH_I;
        end else begin
          parse_ph = PH_SKIP;
        end
      end
      PH_I:      parse_ph = (c == CH_LI) ? PH_L : PH_SKIP;
      PH_L:      parse_ph = (c == CH_LL) ? PH_E : PH_SKIP;
      PH_E:      parse_ph = (c == CH_LE) ? PH_COLON : PH_SKIP;
      PH_COLON:  parse_ph = (c == CH_COLON) ? PH_SLASH1 : PH_SKIP;
      PH_SLASH1: parse_ph = (c == CH_SLASH) ? PH_SLASH2 : PH_SKIP;
      PH_SLASH2: begin
        if (c == CH_SLASH) begin
          parse_ph = PH_HOST0;
        end else begin
          local_host = 1'b1;
          parse_ph   = PH_PATH;
          decode_char(CH_SLASH);
          decode_char(c);
        end
      end
      PH_HOST0, PH_HOST: begin
        if (c == CH_SLASH) begin
          local_host = (parse_ph == PH_HOST0);
          parse_ph   = PH_PATH;
          decode_char(c);
        end else begin
          add_res(KIND_HOST, c, 1'b0, 1'b0, 1'b0);
          parse_ph = PH_HOST;
        end
      end
      PH_PATH, PH_PCT, PH_PCT1: decode_char(c);
      default: parse_ph = PH_SKIP;
    endcase
    if (is_last) begin
      if (parse_ph == PH_SLASH2) begin
        local_host = 1'b1;
        parse_ph   = PH_PATH;
        decode_char(CH_SLASH);
      end
      if (parse_ph == PH_PATH || parse_ph == PH_PCT || parse_ph == PH_PCT1) begin
        if (parse_ph == PH_PCT) begin
          emit_path(CH_PCT);
        end else if (parse_ph == PH_PCT1) begin
          emit_path(CH_PCT);
          emit_path(held_digit);
        end
        if (slash_pending && !path_started) add_res(KIND_PATH, CH_SLASH, 1'b0, 1'b0, 1'b0);
        ok = 1'b1;
      end
      add_res(KIND_STATUS, 8'h00, !ok, ok & local_host, 1'b1);
      clear_parser();
    end
  endfunction

  function automatic void add_row(logic [7:0] c, logic is_last, int n_fixed, item_t res);
    stim_row_t r;
    r.ch        = c;
    r.is_last   = is_last;
    r.n_fixed   = n_fixed;
    r.fixed_res = res;
    stim_table.push_back(r);
  endfunction

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(15);
    if (v < 10) return CH_0 + 8'(v);
    return (($urandom_range(1) != 0) ? CH_UA : CH_LA) + 8'(v - 10);
  endfunction

  function automatic void add_scheme(int n);
    for (int i = 0; i < n; i++) ident_bytes.push_back(SCHEME[55-8*i -: 8]);
  endfunction

  function automatic void add_path(int n);
    repeat (n) begin
      case ($urandom_range(9))
        0, 1: ident_bytes.push_back(CH_SLASH);
        2, 3: begin
          ident_bytes.push_back(CH_PCT);
          ident_bytes.push_back(rand_hex());
          ident_bytes.push_back(rand_hex());
        end
        4: begin
          ident_bytes.push_back(CH_PCT);
          ident_bytes.push_back(rand_hex());
          ident_bytes.push_back(8'($urandom_range(1, 255)));
        end
        5: ident_bytes.push_back(CH_PCT);
        6: ident_bytes.push_back(rand_hex());
        default: ident_bytes.push_back(8'($urandom_range(1, 255)));
      endcase
    end
  endfunction

  function automatic void add_host(int n);
    logic [7:0] hb;
    repeat (n) begin
      hb = 8'($urandom_range(1, 255));
      if (hb == CH_SLASH) hb = "h";
      ident_bytes.push_back(hb);
    end
  endfunction

  // Mostly well-formed identifiers with random content, the rest broken.
  function automatic void build_identifier();
    int k;
    ident_bytes.delete();
    case ($urandom_range(9))
      0, 1: begin
        ident_bytes.push_back(CH_SLASH);
        add_path($urandom_range(6));
      end
      2: begin
        add_scheme(6);
        add_path($urandom_range(6));
      end
      3: begin
        add_scheme(7);
        ident_bytes.push_back(CH_SLASH);
        add_path($urandom_range(5));
      end
      4, 5: begin
        add_scheme(7);
        add_host($urandom_range(1, 4));
        ident_bytes.push_back(CH_SLASH);
        add_path($urandom_range(5));
      end
      6: begin
        add_scheme(5);
        add_host(1);
        add_path($urandom_range(3));
      end
      7: begin
        k = $urandom_range(1, 7);
        add_scheme(k);
        if (k == 7) add_host($urandom_range(3));
      end
      8: begin
        add_scheme(7);
        ident_bytes[$urandom_range(6)] = 8'($urandom_range(1, 255));
        add_path($urandom_range(4));
      end
      default: repeat ($urandom_range(1, 5)) ident_bytes.push_back(8'($urandom_range(1, 255)));
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Called at a falling edge; returns at the falling edge after the request.
  task automatic send_byte(logic [7:0] c, logic is_last, int n_fixed, item_t fixed_res);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.char_in  <= c;
    in_ch.is_final <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_byte(c, is_last);
    if (n_fixed < 0) begin
      foreach (step_res[i]) pending_items.push_back(step_res[i]);
    end else if (n_fixed > 0) begin
      pending_items.push_back(fixed_res);
    end
    bytes_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[file_uri_parser_percent_decode] ERROR");
      $finish;
    end
  end

  initial begin : receiver
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_items.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d byte %02h",
                                  out_ch.item_kind, out_ch.byte_out));
      end else begin
        want = pending_items.pop_front();
        if (out_ch.item_kind !== want.kind)
          report_mismatch($sformatf("item_kind %0d, want %0d", out_ch.item_kind, want.kind));
        if (out_ch.byte_out !== want.data)
          report_mismatch($sformatf("byte_out %02h, want %02h", out_ch.byte_out, want.data));
        if (out_ch.status_code !== want.status)
          report_mismatch($sformatf("status_code %b, want %b", out_ch.status_code, want.status));
        if (out_ch.host_local !== want.host_local)
          report_mismatch($sformatf("host_local %b, want %b", out_ch.host_local,
                                    want.host_local));
        if (out_ch.run_end !== want.run_end)
          report_mismatch($sformatf("run_end %b, want %b", out_ch.run_end, want.run_end));
      end
    end
  end

  initial begin : stimulus
    int target;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.char_in  = 8'h00;
    in_ch.is_final = 1'b0;
    clear_parser();

    // A bad first byte, and an identifier that stops inside the scheme.
    add_row(8'hFF, 1'b1, 1, INVALID_END);
    add_row(CH_LF, 1'b0, 0, INVALID_END);
    add_row(CH_LI, 1'b1, 1, INVALID_END);
    // Nothing but the scheme and one slash.
    for (int i = 0; i < 6; i++) add_row(SCHEME[55-8*i -: 8], i == 5, -1, INVALID_END);
    // A decoded slash at the end is dropped like a plain one.
    add_row(CH_SLASH, 1'b0, -1, INVALID_END);
    add_row(CH_PCT, 1'b0, -1, INVALID_END);
    add_row("2", 1'b0, -1, INVALID_END);
    add_row("F", 1'b1, -1, INVALID_END);
    // Lowercase escape, a zero byte, and an escape cut off by the end.
    add_row(CH_SLASH, 1'b0, -1, INVALID_END);
    add_row(CH_PCT, 1'b0, -1, INVALID_END);
    add_row("4", 1'b0, -1, INVALID_END);
    add_row("a", 1'b0, -1, INVALID_END);
    add_row(8'h00, 1'b0, -1, INVALID_END);
    add_row(CH_PCT, 1'b0, -1, INVALID_END);
    add_row("b", 1'b1, -1, INVALID_END);
    // The byte after "file:" must be a slash.
    for (int i = 0; i < 5; i++) add_row(SCHEME[55-8*i -: 8], 1'b0, 0, INVALID_END);
    add_row(CH_PCT, 1'b1, 1, INVALID_END);

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (stim_table[i])
      send_byte(stim_table[i].ch, stim_table[i].is_last, stim_table[i].n_fixed,
                stim_table[i].fixed_res);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  hold_req = 1'b1; end
        1: begin src_idle_pct = 47; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 47; end
        default: begin src_idle_pct = 25; sink_stall_pct = 25; end
      endcase
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) begin
        build_identifier();
        foreach (ident_bytes[i])
          send_byte(ident_bytes[i], i == ident_bytes.size() - 1, -1, INVALID_END);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_items.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_items.size()));

    if (mismatch_count == 0) begin
      $display("[file_uri_parser_percent_decode] OK");
    end else begin
      $display("[file_uri_parser_percent_decode] ERROR");
    end
    $finish;
  end

endmodule
